>>> rtl/core/tbs_pkg.sv
`timescale 1ns / 1ps
// shared types, character codes and lookup functions for the byte stuffer
// no dependencies
package tbs_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_C = 8'h43;

	// partial match held between words
	typedef enum logic [2:0] {
		MP_NONE = 3'd0,
		MP_F    = 3'd1,
		MP_FL   = 3'd2,
		MP_FLA  = 3'd3,
		MP_E    = 3'd4,
		MP_ES   = 3'd5
	} match_t;

	typedef enum logic [1:0] {
		TOK_NONE    = 2'd0,
		TOK_LIT     = 2'd1,
		TOK_ESCFLAG = 2'd2,
		TOK_ESCESC  = 2'd3
	} tok_t;

	// output run is built from these segments, in this order
	typedef enum logic [2:0] {
		SEG_OPEN  = 3'd0,
		SEG_FA    = 3'd1,
		SEG_TOK   = 3'd2,
		SEG_FB    = 3'd3,
		SEG_CLOSE = 3'd4
	} seg_t;

	localparam int unsigned NUM_SEGS = 5;

	typedef struct packed {
		logic       open_flag;
		logic       fa_esc;
		logic [1:0] fa_len;
		tok_t       tok;
		logic [7:0] ch;
		logic       fb_esc;
		logic [1:0] fb_len;
		logic       close_flag;
	} desc_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} q_head_t;

	function automatic logic [7:0] flag_ch(input logic [1:0] idx);
		case (idx)
			2'd0:    flag_ch = CH_F;
			2'd1:    flag_ch = CH_L;
			2'd2:    flag_ch = CH_A;
			default: flag_ch = CH_G;
		endcase
	endfunction

	function automatic logic [7:0] esc_ch(input logic [1:0] idx);
		case (idx)
			2'd0:    esc_ch = CH_E;
			2'd1:    esc_ch = CH_S;
			default: esc_ch = CH_C;
		endcase
	endfunction

	function automatic logic [1:0] held_len(input match_t m);
		case (m)
			MP_F:    held_len = 2'd1;
			MP_FL:   held_len = 2'd2;
			MP_FLA:  held_len = 2'd3;
			MP_E:    held_len = 2'd1;
			MP_ES:   held_len = 2'd2;
			default: held_len = 2'd0;
		endcase
	endfunction

	function automatic logic held_esc(input match_t m);
		held_esc = (m == MP_E) || (m == MP_ES);
	endfunction

	function automatic logic [2:0] seg_len(input desc_t d, input seg_t s);
		case (s)
			SEG_OPEN:  seg_len = d.open_flag ? 3'd4 : 3'd0;
			SEG_FA:    seg_len = {1'b0, d.fa_len};
			SEG_TOK: begin
				case (d.tok)
					TOK_LIT:     seg_len = 3'd1;
					TOK_ESCFLAG: seg_len = 3'd7;
					TOK_ESCESC:  seg_len = 3'd6;
					default:     seg_len = 3'd0;
				endcase
			end
			SEG_FB:    seg_len = {1'b0, d.fb_len};
			SEG_CLOSE: seg_len = d.close_flag ? 3'd4 : 3'd0;
			default:   seg_len = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] char_at(input desc_t d, input seg_t s, input logic [2:0] idx);
		logic [2:0] off;
		off = 3'(idx - 3'd3);
		case (s)
			SEG_FA:  char_at = d.fa_esc ? esc_ch(idx[1:0]) : flag_ch(idx[1:0]);
			SEG_FB:  char_at = d.fb_esc ? esc_ch(idx[1:0]) : flag_ch(idx[1:0]);
			SEG_TOK: begin
				case (d.tok)
					TOK_ESCFLAG: char_at = (idx < 3'd3) ? esc_ch(idx[1:0]) : flag_ch(off[1:0]);
					TOK_ESCESC:  char_at = (idx < 3'd3) ? esc_ch(idx[1:0]) : esc_ch(off[1:0]);
					default:     char_at = d.ch;
				endcase
			end
			default: char_at = flag_ch(idx[1:0]);
		endcase
	endfunction

endpackage

>>> rtl/core/tbs_front.sv
`timescale 1ns / 1ps
// front end: accepts words, tracks frame and partial match, builds run descriptors
// depends on tbs_pkg
module tbs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // data_char
	input  logic             s_tlast,   // end_of_frame
	input  logic             s_tuser,   // empty_frame
	input  logic             q_full,
	output logic             push,
	output tbs_pkg::desc_t   push_desc
);

	logic            open_q;
	tbs_pkg::match_t match_q;
	logic            open_d;
	tbs_pkg::match_t match_d;
	tbs_pkg::match_t m;
	tbs_pkg::match_t m1;
	tbs_pkg::desc_t  d;
	logic            accept;
	logic            nonempty;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		d          = '0;
		d.tok      = tbs_pkg::TOK_NONE;
		d.ch       = s_tdata;
		m1         = tbs_pkg::MP_NONE;
		open_d     = open_q;
		match_d    = match_q;
		m          = (open_q && match_q <= tbs_pkg::MP_ES) ? match_q : tbs_pkg::MP_NONE;
		if (s_tuser) begin
			d.close_flag = 1'b1;
			if (open_q) begin
				d.fa_esc = tbs_pkg::held_esc(m);
				d.fa_len = tbs_pkg::held_len(m);
			end else begin
				d.open_flag = 1'b1;
			end
			open_d  = 1'b0;
			match_d = tbs_pkg::MP_NONE;
		end else begin
			d.open_flag = !open_q;
			if (m >= tbs_pkg::MP_F && m <= tbs_pkg::MP_FLA &&
			    s_tdata == tbs_pkg::flag_ch(m[1:0])) begin
				if (m == tbs_pkg::MP_FLA) begin
					d.tok = tbs_pkg::TOK_ESCFLAG;
				end else begin
					m1 = tbs_pkg::match_t'(3'(m + 3'd1));
				end
			end else if ((m == tbs_pkg::MP_E && s_tdata == tbs_pkg::CH_S) ||
			             (m == tbs_pkg::MP_ES && s_tdata == tbs_pkg::CH_C)) begin
				if (m == tbs_pkg::MP_ES) begin
					d.tok = tbs_pkg::TOK_ESCESC;
				end else begin
					m1 = tbs_pkg::MP_ES;
				end
			end else begin
				// broken match goes out as literals, then the char is scanned afresh
				d.fa_esc = tbs_pkg::held_esc(m);
				d.fa_len = tbs_pkg::held_len(m);
				if (s_tdata == tbs_pkg::CH_F) begin
					m1 = tbs_pkg::MP_F;
				end else if (s_tdata == tbs_pkg::CH_E) begin
					m1 = tbs_pkg::MP_E;
				end else begin
					d.tok = tbs_pkg::TOK_LIT;
				end
			end
			if (s_tlast) begin
				d.fb_esc     = tbs_pkg::held_esc(m1);
				d.fb_len     = tbs_pkg::held_len(m1);
				d.close_flag = 1'b1;
				open_d       = 1'b0;
				match_d      = tbs_pkg::MP_NONE;
			end else begin
				open_d  = 1'b1;
				match_d = m1;
			end
		end
	end

	// a word that only extends a match gives no output
	assign nonempty  = d.open_flag || d.close_flag || (d.fa_len != 2'd0) ||
	                   (d.fb_len != 2'd0) || (d.tok != tbs_pkg::TOK_NONE);
	assign push      = accept && nonempty;
	assign push_desc = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			match_q <= tbs_pkg::MP_NONE;
		end else if (accept) begin
			open_q  <= open_d;
			match_q <= match_d;
		end
	end

endmodule

>>> rtl/core/tbs_queue.sv
`timescale 1ns / 1ps
// descriptor queue between front and back end, flop based
// depends on tbs_pkg
module tbs_queue #(
	parameter int unsigned Depth = tbs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tbs_pkg::desc_t   push_desc,
	output logic             full,
	input  logic             pop,
	output tbs_pkg::q_head_t head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	tbs_pkg::desc_t  mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CntW'(Depth));
	assign head       = '{valid: (count_q != '0), desc: mem_q[rd_ptr_q]};
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CntW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CntW'(count_q - 1'b1);
			end
		end
	end

endmodule

>>> rtl/core/tbs_back.sv
`timescale 1ns / 1ps
// back end: walks the head descriptor one character a cycle, while m_tready does not stall it, into the output register
// depends on tbs_pkg
module tbs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tbs_pkg::q_head_t head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_char
	output logic             m_tlast,   // out_last
	output logic             m_tuser    // frame_done
);

	tbs_pkg::seg_t seg_q;
	logic [2:0]    idx_q;
	tbs_pkg::seg_t cur_seg;
	tbs_pkg::seg_t sg;
	logic          found;
	logic          later;
	logic [2:0]    cur_len;
	logic          last_in_seg;
	logic          advance;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;
	logic          out_done_q;

	// first non-empty segment at or after the current one, and whether any follows it
	always_comb begin
		cur_seg = tbs_pkg::SEG_CLOSE;
		found   = 1'b0;
		later   = 1'b0;
		sg      = tbs_pkg::SEG_OPEN;
		for (int s = 0; s < tbs_pkg::NUM_SEGS; s++) begin
			sg = tbs_pkg::seg_t'(3'(s));
			if (!found && sg >= seg_q && tbs_pkg::seg_len(head.desc, sg) != 3'd0) begin
				cur_seg = sg;
				found   = 1'b1;
			end
		end
		for (int s = 0; s < tbs_pkg::NUM_SEGS; s++) begin
			sg = tbs_pkg::seg_t'(3'(s));
			if (sg > cur_seg && tbs_pkg::seg_len(head.desc, sg) != 3'd0) begin
				later = 1'b1;
			end
		end
	end

	assign cur_len     = tbs_pkg::seg_len(head.desc, cur_seg);
	assign last_in_seg = (idx_q == 3'(cur_len - 3'd1));
	assign advance     = head.valid && (!out_valid_q || m_tready);
	assign pop         = advance && last_in_seg && !later;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= tbs_pkg::SEG_OPEN;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (!last_in_seg) begin
					seg_q <= cur_seg;
					idx_q <= 3'(idx_q + 3'd1);
				end else if (later) begin
					seg_q <= tbs_pkg::seg_t'(3'(cur_seg + 3'd1));
					idx_q <= '0;
				end else begin
					seg_q <= tbs_pkg::SEG_OPEN;
					idx_q <= '0;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_char_q <= tbs_pkg::char_at(head.desc, cur_seg, idx_q);
			out_last_q <= last_in_seg && !later;
			out_done_q <= (cur_seg == tbs_pkg::SEG_CLOSE) && last_in_seg;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

endmodule

>>> rtl/core/token_byte_stuffer_core.sv
`timescale 1ns / 1ps
// an accepted word is queued, then its first character is registered out with m_tvalid
// throughput: one word per cycle while each word gives one character and m_tready does not
//   stall; a word with more characters holds the output, limited by the back end walker
// the descriptor queue absorbs bursts from escapes and delimiters
// reset: asynchronous, active low; clears frame state, match state, queue and output valid
// top level of the byte stuffer; depends on tbs_pkg, tbs_front, tbs_queue, tbs_back
module token_byte_stuffer_core #(
	parameter int unsigned QueueDepth = tbs_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_char
	input  logic       s_tlast,   // end_of_frame
	input  logic       s_tuser,   // [0] empty_frame
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast,   // out_last
	output logic       m_tuser    // [0] frame_done
);

	logic             q_full;
	logic             push;
	tbs_pkg::desc_t   push_desc;
	logic             pop;
	tbs_pkg::q_head_t head;

	tbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	tbs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	tbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/core/tbs_checker.sv
`timescale 1ns / 1ps
// port level checks for the byte stuffer, bound to the top level
// depends on tbs_pkg and token_byte_stuffer_core
module tbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// frame close always ends the run of its word
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("frame_done without out_last");

	// closing delimiter ends on its final character
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == tbs_pkg::CH_G))
		else $error("frame_done on wrong character");

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("output word changed under stall");

	// an accepted word that cannot just extend a partial match is followed by m_tvalid high
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser || s_tlast ||
		 !(s_tdata == tbs_pkg::CH_F || s_tdata == tbs_pkg::CH_L ||
		   s_tdata == tbs_pkg::CH_A || s_tdata == tbs_pkg::CH_E ||
		   s_tdata == tbs_pkg::CH_S))) |=> ##1 m_tvalid)
		else $error("accepted word gave no output");

endmodule

bind token_byte_stuffer_core tbs_checker u_tbs_checker (.*);
